// ===== hw/rtl/psp_pkg.sv =====
// ----------------------------------------------------------------------------
// psp_pkg
// Shared types and codes of the PPM stream parser: result record, event
// kinds, error codes, parse phases and character constants.
// ----------------------------------------------------------------------------
package psp_pkg;

    // one result record as it leaves the parser
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic [1:0]  chan;
        logic [15:0] column;
        logic [15:0] row;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] maxval;
        logic [2:0]  err;
        logic        last;
    } t_result;

    // event kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NOT_PPM    = 3'd1;
    localparam logic [2:0] ERR_BAD_HEADER = 3'd2;
    localparam logic [2:0] ERR_SIZE       = 3'd3;
    localparam logic [2:0] ERR_DATA_ENDED = 3'd4;
    localparam logic [2:0] ERR_BAD_NUMBER = 3'd5;

    // parse phases
    localparam logic [3:0] PH_MAGIC0    = 4'd0;
    localparam logic [3:0] PH_MAGIC1    = 4'd1;
    localparam logic [3:0] PH_MAGIC_SEP = 4'd2;
    localparam logic [3:0] PH_HDR_W     = 4'd3;
    localparam logic [3:0] PH_HDR_H     = 4'd4;
    localparam logic [3:0] PH_HDR_M     = 4'd5;
    localparam logic [3:0] PH_BIN       = 4'd6;
    localparam logic [3:0] PH_ASC       = 4'd7;
    localparam logic [3:0] PH_TRAIL     = 4'd8;

    // characters
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // binary samples take two bytes from this maxval up
    localparam logic [31:0] WIDE_SAMPLE = 32'd256;
    // files shorter than this many bytes are not ppm
    localparam logic [3:0]  MIN_FILE_BYTES = 4'd12;

endpackage

// ===== hw/rtl/psp_fifo.sv =====
// ----------------------------------------------------------------------------
// psp_fifo
// Four-entry result queue: takes zero, one or two records per cycle and
// hands out one record per beat.
// ----------------------------------------------------------------------------
module psp_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_cnt,
    input  psp_pkg::t_result  i_push0,
    input  psp_pkg::t_result  i_push1,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output psp_pkg::t_result  o_data
);

    psp_pkg::t_result r_mem [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;
    logic       pop;
    logic [1:0] wr_next;

    assign o_valid = (r_cnt != 3'd0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd];
    // room for the worst case of two records from one byte
    assign o_space = (r_cnt <= 3'd2);
    assign wr_next = r_wr + 2'd1;

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_push0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr_next] <= i_push1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wr  <= r_wr + i_push_cnt;
            r_rd  <= r_rd + {1'b0, pop};
            r_cnt <= r_cnt + {1'b0, i_push_cnt} - {2'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 3'd0) |=> (r_cnt <= {1'b0, $past(i_push_cnt)}))
        else $error("result queue underflow");

    a_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_cnt != 2'd0) |-> (r_cnt <= 3'd2))
        else $error("push without room");

endmodule

// ===== hw/rtl/ppm_stream_parser.sv =====
// ----------------------------------------------------------------------------
// ppm_stream_parser
// Byte-serial PPM (P6 binary / P3 ASCII) decoder with streaming ports.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one file byte per beat on i_s_tdata, i_s_tlast on the
//   final byte of the file. Master channel: one event per beat, kind on
//   o_m_tuser (header, sample, end ok, error), o_m_tlast on the last event
//   caused by a given input byte.
//   Each accepted byte is decoded in the cycle it is accepted; its events
//   are written into a four-entry queue register and offered on the
//   master side from the head of that queue.
//   Throughput is one byte per cycle. A byte that yields two events (a
//   sample plus end/error, a header plus error) needs two master beats;
//   o_s_tready drops while fewer than two queue entries are free, so the
//   queue depth and the one-event-per-beat drain set the rate.
//   When the receiver stalls, events wait in the queue and input is taken
//   until fewer than two queue entries are free.
//   Reset (synchronous, active low) returns the parser to expecting the
//   first magic byte and empties the queue. Every end-of-file byte also
//   returns the parser to that state, so files may follow back to back.
// ----------------------------------------------------------------------------
module ppm_stream_parser #(
    parameter int DIM_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // slave: data_byte[7:0]
    input  logic [7:0]    i_s_tdata,
    input  logic          i_s_tlast,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // master: sample_value[15:0], channel[17:16], column[33:18], row[49:34],
    // image_width[65:50], image_height[81:66], max_value[97:82],
    // error_code[100:98], zero pad [103:101]
    output logic [103:0]  o_m_tdata,
    // master: event_kind[1:0]
    output logic [1:0]    o_m_tuser,
    output logic          o_m_tlast,
    output logic          o_m_tvalid,
    input  logic          i_m_tready
);

    localparam int ACC_W = (DIM_BITS >= 16) ? DIM_BITS + 1 : 17;

    logic [3:0]          r_phase, n_phase;
    logic                r_ascii, n_ascii;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic                r_seen, n_seen;
    logic [ACC_W-1:0]    r_width, n_width;
    logic [ACC_W-1:0]    r_height, n_height;
    logic [ACC_W-1:0]    r_maxval, n_maxval;
    logic [DIM_BITS-1:0] r_col, n_col;
    logic [DIM_BITS-1:0] r_row, n_row;
    logic [1:0]          r_chan, n_chan;
    logic [7:0]          r_hold, n_hold;
    logic                r_half, n_half;
    logic [3:0]          r_hbc, n_hbc;
    logic                r_err, n_err;

    logic                fire;
    logic [7:0]          b;
    logic                eof;
    logic                dig;
    logic                ws;
    logic [ACC_W+3:0]    acc_wide;
    logic [ACC_W-1:0]    acc_next;
    logic [DIM_BITS+15:0] col_ext;
    logic [DIM_BITS+15:0] row_ext;
    logic [DIM_BITS:0]   col_inc;
    logic [DIM_BITS:0]   row_inc;

    logic                hdr_a;
    logic                fail_a;
    logic [2:0]          fail_code;
    logic                take;
    logic [ACC_W-1:0]    samp_val;
    logic                done;
    logic                end_a;
    logic                ended;
    logic [1:0]          nres;

    psp_pkg::t_result    res [2];
    psp_pkg::t_result    q_data;
    logic                q_space;

    function automatic psp_pkg::t_result mk(
        input logic [1:0]  kind,
        input logic [15:0] value,
        input logic [1:0]  chan,
        input logic [15:0] column,
        input logic [15:0] row,
        input logic [15:0] w,
        input logic [15:0] h,
        input logic [15:0] m,
        input logic [2:0]  err
    );
        psp_pkg::t_result t;
        t.kind   = kind;
        t.value  = value;
        t.chan   = chan;
        t.column = column;
        t.row    = row;
        t.width  = w;
        t.height = h;
        t.maxval = m;
        t.err    = err;
        t.last   = 1'b0;
        return t;
    endfunction

    assign fire = i_s_tvalid && o_s_tready;
    assign b    = i_s_tdata;
    assign eof  = i_s_tlast;
    assign dig  = (b >= psp_pkg::CH_0) && (b <= psp_pkg::CH_9);
    assign ws   = (b == psp_pkg::CH_SPACE) || ((b >= psp_pkg::CH_TAB) && (b <= psp_pkg::CH_CR));

    // acc * 10 + digit, saturating at all ones
    assign acc_wide = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1)
                    + {{ACC_W{1'b0}}, (b[3:0] - psp_pkg::CH_0[3:0])};
    assign acc_next = (acc_wide[ACC_W+3:ACC_W] != 4'd0) ? {ACC_W{1'b1}} : acc_wide[ACC_W-1:0];

    assign col_ext = {16'd0, r_col};
    assign row_ext = {16'd0, r_row};
    assign col_inc = {1'b0, r_col} + {{DIM_BITS{1'b0}}, 1'b1};
    assign row_inc = {1'b0, r_row} + {{DIM_BITS{1'b0}}, 1'b1};

    always_comb begin
        n_phase  = r_phase;
        n_ascii  = r_ascii;
        n_acc    = r_acc;
        n_seen   = r_seen;
        n_width  = r_width;
        n_height = r_height;
        n_maxval = r_maxval;
        n_col    = r_col;
        n_row    = r_row;
        n_chan   = r_chan;
        n_hold   = r_hold;
        n_half   = r_half;
        n_hbc    = r_hbc;
        n_err    = r_err;
        hdr_a     = 1'b0;
        fail_a    = 1'b0;
        fail_code = psp_pkg::ERR_NONE;
        take      = 1'b0;
        samp_val  = '0;
        done      = 1'b0;
        end_a     = 1'b0;
        ended     = 1'b0;
        nres      = 2'd0;
        res[0]    = '0;
        res[1]    = '0;

        if (fire) begin
            if (r_hbc < psp_pkg::MIN_FILE_BYTES) begin
                n_hbc = r_hbc + 4'd1;
            end

            if (!r_err) begin
                unique case (r_phase) inside
                    psp_pkg::PH_MAGIC0: begin
                        if (b == psp_pkg::CH_P) begin
                            n_phase = psp_pkg::PH_MAGIC1;
                        end else begin
                            fail_a    = 1'b1;
                            fail_code = psp_pkg::ERR_NOT_PPM;
                        end
                    end
                    psp_pkg::PH_MAGIC1: begin
                        if (b == psp_pkg::CH_6 || b == psp_pkg::CH_3) begin
                            n_ascii = (b == psp_pkg::CH_3);
                            n_phase = psp_pkg::PH_MAGIC_SEP;
                        end else begin
                            fail_a    = 1'b1;
                            fail_code = psp_pkg::ERR_NOT_PPM;
                        end
                    end
                    psp_pkg::PH_MAGIC_SEP: begin
                        if (ws) begin
                            n_phase = psp_pkg::PH_HDR_W;
                        end else begin
                            fail_a    = 1'b1;
                            fail_code = psp_pkg::ERR_BAD_HEADER;
                        end
                    end
                    psp_pkg::PH_HDR_W, psp_pkg::PH_HDR_H, psp_pkg::PH_HDR_M: begin
                        if (dig) begin
                            n_acc  = acc_next;
                            n_seen = 1'b1;
                        end else if (ws) begin
                            if (r_seen) begin
                                if (r_phase == psp_pkg::PH_HDR_W) begin
                                    n_width = r_acc;
                                end else if (r_phase == psp_pkg::PH_HDR_H) begin
                                    n_height = r_acc;
                                end else begin
                                    n_maxval = r_acc;
                                end
                                n_acc  = '0;
                                n_seen = 1'b0;
                                if (r_phase == psp_pkg::PH_HDR_M) begin
                                    if (r_width == '0 || r_width[ACC_W-1:DIM_BITS] != '0 ||
                                        r_height == '0 || r_height[ACC_W-1:DIM_BITS] != '0 ||
                                        r_acc == '0 || r_acc[ACC_W-1:16] != '0) begin
                                        fail_a    = 1'b1;
                                        fail_code = psp_pkg::ERR_BAD_HEADER;
                                    end else begin
                                        hdr_a   = 1'b1;
                                        n_phase = r_ascii ? psp_pkg::PH_ASC : psp_pkg::PH_BIN;
                                    end
                                end else begin
                                    n_phase = r_phase + 4'd1;
                                end
                            end
                        end else begin
                            fail_a    = 1'b1;
                            fail_code = psp_pkg::ERR_BAD_HEADER;
                        end
                    end
                    psp_pkg::PH_BIN: begin
                        if (r_maxval >= psp_pkg::WIDE_SAMPLE[ACC_W-1:0]) begin
                            if (!r_half) begin
                                n_hold = b;
                                n_half = 1'b1;
                            end else begin
                                n_half   = 1'b0;
                                take     = 1'b1;
                                samp_val = {{(ACC_W-16){1'b0}}, r_hold, b};
                            end
                        end else begin
                            take     = 1'b1;
                            samp_val = {{(ACC_W-8){1'b0}}, b};
                        end
                    end
                    psp_pkg::PH_ASC: begin
                        if (!dig && !ws) begin
                            fail_a    = 1'b1;
                            fail_code = psp_pkg::ERR_BAD_NUMBER;
                        end else if (r_seen || dig) begin
                            if (dig) begin
                                n_acc  = acc_next;
                                n_seen = 1'b1;
                            end
                            // a digit on the final byte also closes the number
                            if (ws || eof) begin
                                take     = 1'b1;
                                samp_val = dig ? acc_next : r_acc;
                                n_acc    = '0;
                                n_seen   = 1'b0;
                            end
                        end
                    end
                    default: begin
                        if (!ws) begin
                            fail_a    = 1'b1;
                            fail_code = psp_pkg::ERR_SIZE;
                        end else if (eof) begin
                            end_a = 1'b1;
                        end
                    end
                endcase
            end

            if (hdr_a) begin
                res[nres[0]] = mk(psp_pkg::KIND_HEADER, 16'd0, 2'd0, 16'd0, 16'd0,
                                  n_width[15:0], n_height[15:0], n_maxval[15:0],
                                  psp_pkg::ERR_NONE);
                nres = nres + 2'd1;
            end
            if (fail_a) begin
                res[nres[0]] = mk(psp_pkg::KIND_ERROR, 16'd0, 2'd0, 16'd0, 16'd0,
                                  n_width[15:0], n_height[15:0], n_maxval[15:0],
                                  fail_code);
                nres  = nres + 2'd1;
                n_err = 1'b1;
            end
            if (end_a) begin
                res[nres[0]] = mk(psp_pkg::KIND_END, 16'd0, 2'd0, 16'd0, 16'd0,
                                  n_width[15:0], n_height[15:0], n_maxval[15:0],
                                  psp_pkg::ERR_NONE);
                nres  = nres + 2'd1;
                ended = 1'b1;
            end

            if (take) begin
                if (samp_val > n_maxval) begin
                    res[nres[0]] = mk(psp_pkg::KIND_ERROR, 16'd0, 2'd0, 16'd0, 16'd0,
                                      n_width[15:0], n_height[15:0], n_maxval[15:0],
                                      psp_pkg::ERR_BAD_NUMBER);
                    nres  = nres + 2'd1;
                    n_err = 1'b1;
                end else begin
                    res[nres[0]] = mk(psp_pkg::KIND_SAMPLE, samp_val[15:0], r_chan,
                                      col_ext[15:0], row_ext[15:0],
                                      n_width[15:0], n_height[15:0], n_maxval[15:0],
                                      psp_pkg::ERR_NONE);
                    nres = nres + 2'd1;
                    // advance channel, then column, then row
                    if (r_chan == 2'd2) begin
                        n_chan = 2'd0;
                        if (col_inc == n_width[DIM_BITS:0]) begin
                            n_col = '0;
                            n_row = row_inc[DIM_BITS-1:0];
                            done  = (row_inc == n_height[DIM_BITS:0]);
                        end else begin
                            n_col = col_inc[DIM_BITS-1:0];
                        end
                    end else begin
                        n_chan = r_chan + 2'd1;
                    end
                    if (done) begin
                        if (eof) begin
                            res[nres[0]] = mk(psp_pkg::KIND_END, 16'd0, 2'd0, 16'd0, 16'd0,
                                              n_width[15:0], n_height[15:0], n_maxval[15:0],
                                              psp_pkg::ERR_NONE);
                            nres  = nres + 2'd1;
                            ended = 1'b1;
                        end else if (r_phase == psp_pkg::PH_BIN) begin
                            res[nres[0]] = mk(psp_pkg::KIND_ERROR, 16'd0, 2'd0, 16'd0, 16'd0,
                                              n_width[15:0], n_height[15:0], n_maxval[15:0],
                                              psp_pkg::ERR_SIZE);
                            nres  = nres + 2'd1;
                            n_err = 1'b1;
                        end else begin
                            n_phase = psp_pkg::PH_TRAIL;
                        end
                    end
                end
            end

            // early end of file
            if (eof && !n_err && !ended) begin
                if (n_hbc < psp_pkg::MIN_FILE_BYTES) begin
                    fail_code = psp_pkg::ERR_NOT_PPM;
                end else if (n_phase == psp_pkg::PH_BIN) begin
                    fail_code = psp_pkg::ERR_SIZE;
                end else if (n_phase == psp_pkg::PH_ASC) begin
                    fail_code = psp_pkg::ERR_DATA_ENDED;
                end else begin
                    fail_code = psp_pkg::ERR_BAD_HEADER;
                end
                res[nres[0]] = mk(psp_pkg::KIND_ERROR, 16'd0, 2'd0, 16'd0, 16'd0,
                                  n_width[15:0], n_height[15:0], n_maxval[15:0],
                                  fail_code);
                nres = nres + 2'd1;
            end

            if (nres == 2'd1) begin
                res[0].last = 1'b1;
            end else if (nres == 2'd2) begin
                res[1].last = 1'b1;
            end

            // every end of file returns to the reset state
            if (eof) begin
                n_phase  = psp_pkg::PH_MAGIC0;
                n_ascii  = 1'b0;
                n_acc    = '0;
                n_seen   = 1'b0;
                n_width  = '0;
                n_height = '0;
                n_maxval = '0;
                n_col    = '0;
                n_row    = '0;
                n_chan   = 2'd0;
                n_hold   = 8'd0;
                n_half   = 1'b0;
                n_hbc    = 4'd0;
                n_err    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= psp_pkg::PH_MAGIC0;
            r_ascii  <= 1'b0;
            r_acc    <= '0;
            r_seen   <= 1'b0;
            r_width  <= '0;
            r_height <= '0;
            r_maxval <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_chan   <= 2'd0;
            r_hold   <= 8'd0;
            r_half   <= 1'b0;
            r_hbc    <= 4'd0;
            r_err    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_ascii  <= n_ascii;
            r_acc    <= n_acc;
            r_seen   <= n_seen;
            r_width  <= n_width;
            r_height <= n_height;
            r_maxval <= n_maxval;
            r_col    <= n_col;
            r_row    <= n_row;
            r_chan   <= n_chan;
            r_hold   <= n_hold;
            r_half   <= n_half;
            r_hbc    <= n_hbc;
            r_err    <= n_err;
        end
    end

    psp_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (nres),
        .i_push0    (res[0]),
        .i_push1    (res[1]),
        .o_space    (q_space),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_data     (q_data)
    );

    assign o_s_tready = q_space;
    assign o_m_tuser  = q_data.kind;
    assign o_m_tlast  = q_data.last;
    assign o_m_tdata  = {3'd0, q_data.err, q_data.maxval, q_data.height, q_data.width,
                         q_data.row, q_data.column, q_data.chan, q_data.value};

    a_eof_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_s_tlast) |=> (r_phase == psp_pkg::PH_MAGIC0 && !r_err && r_hbc == 4'd0))
        else $error("state not cleared after end of file");

    a_silent_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_err) |-> (nres == 2'd0))
        else $error("result produced after an error");

    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chan != 2'd3)
        else $error("channel counter out of range");

    a_half_in_binary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (r_phase == psp_pkg::PH_BIN))
        else $error("byte pair pending outside binary data");

    a_col_in_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == psp_pkg::PH_BIN || r_phase == psp_pkg::PH_ASC) |->
        ({{(ACC_W-DIM_BITS){1'b0}}, r_col} < r_width))
        else $error("column beyond image width");

endmodule
